// ----- sv/gled_pkg.sv -----
// Package for the grid/ring LED serial command decoder.
// Command codes, argument counts and level gating; no dependencies.
`timescale 1ns / 1ps

package gled_pkg;

  localparam int LED_COUNT_DEF = 512;
  localparam int ID_BYTES_DEF  = 32;
  localparam int RING_SIZE_DEF = 64;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_THR  = 2'd2;

  localparam logic [7:0] CMD_QUERY      = 8'h00;
  localparam logic [7:0] CMD_ID_Q       = 8'h01;
  localparam logic [7:0] CMD_ID_WR      = 8'h02;
  localparam logic [7:0] CMD_OFS_Q      = 8'h03;
  localparam logic [7:0] CMD_OFS_WR     = 8'h04;
  localparam logic [7:0] CMD_SIZE_Q     = 8'h05;
  localparam logic [7:0] CMD_SIZE_WR    = 8'h06;
  localparam logic [7:0] CMD_ADDR_WR    = 8'h08;
  localparam logic [7:0] CMD_FW_WR      = 8'h0F;
  localparam logic [7:0] CMD_LED_OFF    = 8'h10;
  localparam logic [7:0] CMD_LED_ON     = 8'h11;
  localparam logic [7:0] CMD_ALL_OFF    = 8'h12;
  localparam logic [7:0] CMD_ALL_ON     = 8'h13;
  localparam logic [7:0] CMD_MAP        = 8'h14;
  localparam logic [7:0] CMD_ROW        = 8'h15;
  localparam logic [7:0] CMD_COL        = 8'h16;
  localparam logic [7:0] CMD_INTENSITY  = 8'h17;
  localparam logic [7:0] CMD_LVL_SET    = 8'h18;
  localparam logic [7:0] CMD_LVL_ALL    = 8'h19;
  localparam logic [7:0] CMD_LVL_MAP    = 8'h1A;
  localparam logic [7:0] CMD_LVL_ROW    = 8'h1B;
  localparam logic [7:0] CMD_LVL_COL    = 8'h1C;
  localparam logic [7:0] CMD_KEY_UP     = 8'h20;
  localparam logic [7:0] CMD_KEY_DN     = 8'h21;
  localparam logic [7:0] CMD_ENC_DELTA  = 8'h50;
  localparam logic [7:0] CMD_ENC_UP     = 8'h51;
  localparam logic [7:0] CMD_ENC_DN     = 8'h52;
  localparam logic [7:0] CMD_RING_SET   = 8'h90;
  localparam logic [7:0] CMD_RING_ALL   = 8'h91;
  localparam logic [7:0] CMD_RING_MAP   = 8'h92;
  localparam logic [7:0] CMD_RING_RANGE = 8'h93;
  localparam logic [7:0] CMD_RGB        = 8'hC0;
  localparam logic [7:0] CMD_BRIGHT     = 8'hC1;
  localparam logic [7:0] CMD_RGB_EXT    = 8'hC2;
  localparam logic [7:0] CMD_COLOR_Q    = 8'hC3;

  localparam logic [7:0] LVL_FULL = 8'h0F;

  function automatic logic [5:0] arg_total(input logic [7:0] c, input logic [5:0] ring_map);
    logic [5:0] t;
    t = 6'd0;
    case (c)
      CMD_ID_WR: t = 6'd32;
      CMD_OFS_WR, CMD_COL, CMD_ROW, CMD_LVL_SET, CMD_RING_SET, CMD_RGB: t = 6'd3;
      CMD_SIZE_WR, CMD_ADDR_WR, CMD_LED_OFF, CMD_LED_ON, CMD_KEY_UP, CMD_KEY_DN,
      CMD_ENC_DELTA, CMD_RING_ALL: t = 6'd2;
      CMD_FW_WR: t = 6'd8;
      CMD_MAP: t = 6'd10;
      CMD_INTENSITY, CMD_LVL_ALL, CMD_ENC_UP, CMD_ENC_DN, CMD_BRIGHT: t = 6'd1;
      CMD_LVL_MAP: t = 6'd34;
      CMD_LVL_ROW, CMD_LVL_COL: t = 6'd6;
      CMD_RING_MAP: t = ring_map;
      CMD_RING_RANGE: t = 6'd4;
      CMD_RGB_EXT: t = 6'd5;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] gate(input logic [3:0] nib, input logic [3:0] thr);
    return (nib > thr) ? {4'h0, nib} : 8'h00;
  endfunction

endpackage

// ----- sv/gled_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module gled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/grid_led_serial_command_decoder.sv -----
// Grid/ring LED serial command decoder: byte stream in, reply words out.
// Depends on gled_pkg and gled_ram.
// Timing: a byte is decoded in the cycle after acceptance; a reply word is then registered in
// the output register, the query reply only after a divide in ST_DIV. LED writes follow
// at one per cycle (up to 8 for grid commands, up to 256 for a ring range, LED_COUNT for a
// fill). Replies leave at one word per cycle while out_tready is high, the ID reply with a
// RAM read state between words. Input waits (in_tready low) until the decoder is idle again.
// Reset: synchronous; afterwards a clearing pass over every LED address zeroes both RAMs.
`timescale 1ns / 1ps

module grid_led_serial_command_decoder
  import gled_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF,
  parameter int ID_BYTES  = ID_BYTES_DEF,
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] rx_byte, [16:8] led_index, rest zero
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata
);

  localparam int LED_AW = $clog2(LED_COUNT);
  localparam int ID_AW  = $clog2(ID_BYTES);
  localparam int RIDX_W = $clog2(256 * RING_SIZE + 1);
  localparam logic [5:0] RING_MAP_ARGS = 6'(1 + RING_SIZE / 2);
  localparam logic [7:0] RING_LAST = 8'(RING_SIZE - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DEC, ST_WALK, ST_DIV, ST_REP,
    ST_ID_EM, ST_ID_RD, ST_LRD, ST_LEM
  } state_t;

  typedef enum logic [1:0] {WK_FILL, WK_GRID, WK_RING} walk_t;

  state_t state_r;
  walk_t  wk_r;

  logic [5:0] cols_r;
  logic [4:0] rows_r;
  logic [3:0] thr_r;

  logic       cmdv_r;
  logic [7:0] pend_r;
  logic [5:0] argc_r;
  logic [7:0] args_r [4];
  logic [7:0] red_r, green_r, blue_r, bright_r;

  logic [7:0] byte_r;
  logic [8:0] rd_idx_r;

  logic [LED_AW-1:0] fill_r;
  logic [7:0] wx_r, wy_r, wn_r, wp_r, wend_r;
  logic       horiz_r, bitmap_r, wrap_r;
  logic [2:0] left_r;
  logic [7:0] bits_r, lvl_r, lvl_b_r;

  logic [5:0] dvd_r;
  logic [4:0] rem_r;
  logic [4:0] quo_r;
  logic [2:0] dcnt_r;

  logic [7:0] rep_r [6];
  logic [2:0] rep_n_r, rep_i_r;
  logic [5:0] idc_r;

  logic       out_valid_r, out_kind_r, out_last_r;
  logic [7:0] out_data_r;

  // decode
  logic [7:0] c_sel, run_b, ox, oy, kb;
  logic [5:0] tot;
  logic       finish;
  logic [7:0] args_u [4];

  always_comb begin
    c_sel  = cmdv_r ? pend_r : byte_r;
    tot    = arg_total(c_sel, RING_MAP_ARGS);
    finish = cmdv_r ? ((argc_r + 6'd1) >= tot) : (tot == 6'd0);
    run_b  = cmdv_r ? byte_r : 8'h00;
    ox     = args_r[0] & 8'h08;
    oy     = args_r[1] & 8'h08;
    kb     = 8'(argc_r);
    for (int i = 0; i < 4; i++) begin
      args_u[i] = (cmdv_r && argc_r == 6'(i)) ? byte_r : args_r[i];
    end
  end

  // divider step
  logic [5:0] div_sh;
  logic       div_ge;
  logic [4:0] div_q;
  assign div_sh = {rem_r, dvd_r[5]};
  assign div_ge = div_sh >= {1'b0, rows_r};
  assign div_q  = {quo_r[3:0], div_ge};

  // LED address generation
  logic [11:0]       gidx;
  logic              gvalid;
  logic [RIDX_W-1:0] ridx;
  logic              rvalid;
  assign gidx   = 12'(wy_r[4:0]) * 12'(cols_r) + 12'(wx_r);
  assign gvalid = (wx_r < {2'b00, cols_r}) && (wy_r < {3'b000, rows_r}) &&
                  (gidx < 12'(LED_COUNT));
  assign ridx   = RIDX_W'(wn_r) * RIDX_W'(RING_SIZE) + RIDX_W'(wp_r);
  assign rvalid = ridx < RIDX_W'(LED_COUNT);

  logic              led_we;
  logic [LED_AW-1:0] led_waddr, led_raddr;
  logic [7:0]        led_wdata, led_rdata;
  logic              id_we;
  logic [ID_AW-1:0]  id_waddr, id_raddr;
  logic [7:0]        id_wdata, id_rdata;
  logic [4:0]        id_ptr;
  logic              out_free;
  logic              out_load;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = out_free &&
                    (state_r == ST_REP || state_r == ST_ID_EM || state_r == ST_LEM);
  assign id_ptr   = 5'(idc_r - 6'd1);

  always_comb begin
    led_we    = 1'b0;
    led_waddr = fill_r;
    led_wdata = 8'h00;
    if (state_r == ST_CLEAR) begin
      led_we = 1'b1;
    end else if (state_r == ST_WALK) begin
      unique case (wk_r)
        WK_FILL: begin
          led_we    = 1'b1;
          led_wdata = lvl_r;
        end
        WK_GRID: begin
          led_we    = gvalid;
          led_waddr = LED_AW'(gidx);
          led_wdata = bitmap_r ? (bits_r[0] ? LVL_FULL : 8'h00) : lvl_r;
        end
        WK_RING: begin
          led_we    = rvalid;
          led_waddr = LED_AW'(ridx);
          led_wdata = lvl_r;
        end
        default: led_we = 1'b0;
      endcase
    end
    led_raddr = LED_AW'(rd_idx_r);

    id_we    = 1'b0;
    id_waddr = ID_AW'(fill_r);
    id_wdata = 8'h00;
    if (state_r == ST_CLEAR) begin
      id_we = {1'b0, fill_r} < (LED_AW + 1)'(ID_BYTES);
    end else if (state_r == ST_DEC && cmdv_r && pend_r == CMD_ID_WR) begin
      id_we    = 7'(argc_r) < 7'(ID_BYTES);
      id_waddr = ID_AW'(argc_r);
      id_wdata = byte_r;
    end
    id_raddr = ID_AW'(id_ptr);
  end

  gled_ram #(.WIDTH(8), .DEPTH(LED_COUNT)) u_led_ram (
    .clk   (clk),
    .we    (led_we),
    .waddr (led_waddr),
    .wdata (led_wdata),
    .raddr (led_raddr),
    .rdata (led_rdata)
  );

  gled_ram #(.WIDTH(8), .DEPTH(ID_BYTES)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      wk_r        <= WK_FILL;
      fill_r      <= '0;
      cols_r      <= 6'd16;
      rows_r      <= 5'd8;
      thr_r       <= 4'd0;
      cmdv_r      <= 1'b0;
      pend_r      <= 8'h00;
      argc_r      <= 6'd0;
      for (int i = 0; i < 4; i++) args_r[i] <= 8'h00;
      red_r       <= 8'h00;
      green_r     <= 8'h00;
      blue_r      <= 8'h00;
      bright_r    <= 8'h00;
      out_valid_r <= 1'b0;
      rep_i_r     <= 3'd0;
      rep_n_r     <= 3'd0;
      idc_r       <= 6'd0;
      dcnt_r      <= 3'd0;
      left_r      <= 3'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_COLS: cols_r <= cfg_wdata;
          CFG_ROWS: rows_r <= cfg_wdata[4:0];
          CFG_THR:  thr_r  <= cfg_wdata[3:0];
          default:  ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (fill_r == LED_AW'(LED_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            fill_r <= fill_r + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_tvalid) begin
            byte_r   <= in_tdata[7:0];
            rd_idx_r <= in_tdata[16:8];
            state_r  <= in_tuser ? ST_LRD : ST_DEC;
          end
        end

        ST_LRD: state_r <= ST_LEM;

        ST_LEM: begin
          if (out_free) begin
            out_kind_r  <= 1'b1;
            out_last_r  <= 1'b1;
            out_data_r  <= (11'(rd_idx_r) < 11'(LED_COUNT)) ? led_rdata : 8'h00;
            state_r     <= ST_IDLE;
          end
        end

        ST_DEC: begin
          if (!cmdv_r && tot != 6'd0) begin
            state_r <= ST_IDLE;
            cmdv_r  <= 1'b1;
            pend_r  <= byte_r;
            argc_r  <= 6'd0;
          end else begin
            if (cmdv_r) begin
              for (int i = 0; i < 4; i++) args_r[i] <= args_u[i];
              if (finish) begin
                cmdv_r <= 1'b0;
                argc_r <= 6'd0;
              end else begin
                argc_r <= argc_r + 6'd1;
              end
            end
            // per-argument writes of map commands
            if (cmdv_r && argc_r >= 6'd2 &&
                (pend_r == CMD_MAP || pend_r == CMD_LVL_MAP ||
                 pend_r == CMD_LVL_ROW || pend_r == CMD_LVL_COL)) begin
              state_r  <= ST_WALK;
              wk_r     <= WK_GRID;
              bits_r   <= byte_r;
              lvl_r    <= gate(byte_r[7:4], thr_r);
              lvl_b_r  <= gate(byte_r[3:0], thr_r);
              bitmap_r <= (pend_r == CMD_MAP);
              left_r   <= (pend_r == CMD_MAP) ? 3'd7 : 3'd1;
              horiz_r  <= (pend_r != CMD_LVL_COL);
              unique case (pend_r)
                CMD_MAP: begin
                  wx_r <= ox;
                  wy_r <= oy + kb - 8'd2;
                end
                CMD_LVL_MAP: begin
                  wx_r <= ox + ((8'd2 * (kb - 8'd2)) & 8'h07);
                  wy_r <= oy + ((8'd2 * (kb - 8'd2)) >> 3);
                end
                CMD_LVL_ROW: begin
                  wx_r <= ox + 8'd2 * (kb - 8'd2);
                  wy_r <= oy;
                end
                default: begin
                  wx_r <= ox;
                  wy_r <= oy + 8'd2 * (kb - 8'd2);
                end
              endcase
            end else if (cmdv_r && argc_r >= 6'd1 && pend_r == CMD_RING_MAP) begin
              state_r <= ST_WALK;
              wk_r    <= WK_RING;
              wn_r    <= args_r[0];
              wp_r    <= 8'd2 * (kb - 8'd1);
              wend_r  <= 8'd2 * (kb - 8'd1) + 8'd1;
              wrap_r  <= 1'b0;
              lvl_r   <= {4'h0, byte_r[7:4]};
              lvl_b_r <= {4'h0, byte_r[3:0]};
            end else if (finish) begin
              unique case (c_sel)
                CMD_QUERY: begin
                  dvd_r   <= cols_r;
                  rem_r   <= 5'd0;
                  quo_r   <= 5'd0;
                  dcnt_r  <= 3'd0;
                  state_r <= ST_DIV;
                end
                CMD_ID_Q: begin
                  idc_r   <= 6'd0;
                  state_r <= ST_ID_EM;
                end
                CMD_OFS_Q: begin
                  rep_r[0] <= 8'h02;
                  rep_r[1] <= 8'h01;
                  rep_r[2] <= 8'h00;
                  rep_r[3] <= 8'h00;
                  rep_n_r  <= 3'd4;
                  rep_i_r  <= 3'd0;
                  state_r  <= ST_REP;
                end
                CMD_SIZE_Q: begin
                  rep_r[0] <= 8'h03;
                  rep_r[1] <= {2'b00, cols_r};
                  rep_r[2] <= {3'b000, rows_r};
                  rep_n_r  <= 3'd3;
                  rep_i_r  <= 3'd0;
                  state_r  <= ST_REP;
                end
                CMD_KEY_UP, CMD_KEY_DN: begin
                  rep_r[0] <= c_sel;
                  rep_r[1] <= args_u[0];
                  rep_r[2] <= run_b;
                  rep_r[3] <= c_sel & 8'h01;
                  rep_n_r  <= 3'd4;
                  rep_i_r  <= 3'd0;
                  state_r  <= ST_REP;
                end
                CMD_ENC_DELTA: begin
                  rep_r[0] <= c_sel;
                  rep_r[1] <= args_u[0];
                  rep_r[2] <= run_b;
                  rep_n_r  <= 3'd3;
                  rep_i_r  <= 3'd0;
                  state_r  <= ST_REP;
                end
                CMD_COLOR_Q: begin
                  rep_r[0] <= c_sel;
                  rep_r[1] <= red_r;
                  rep_r[2] <= green_r;
                  rep_r[3] <= blue_r;
                  rep_r[4] <= bright_r;
                  rep_n_r  <= 3'd5;
                  rep_i_r  <= 3'd0;
                  state_r  <= ST_REP;
                end
                CMD_LED_OFF, CMD_LED_ON, CMD_LVL_SET: begin
                  state_r  <= ST_WALK;
                  wk_r     <= WK_GRID;
                  wx_r     <= args_u[0];
                  wy_r     <= (c_sel == CMD_LVL_SET) ? args_u[1] : run_b;
                  lvl_r    <= (c_sel == CMD_LVL_SET) ? run_b :
                              ((c_sel == CMD_LED_ON) ? LVL_FULL : 8'h00);
                  bitmap_r <= 1'b0;
                  horiz_r  <= 1'b1;
                  left_r   <= 3'd0;
                end
                CMD_ROW, CMD_COL: begin
                  state_r  <= ST_WALK;
                  wk_r     <= WK_GRID;
                  wx_r     <= (c_sel == CMD_ROW) ? (args_u[0] & 8'h08) : args_u[0];
                  wy_r     <= (c_sel == CMD_ROW) ? args_u[1] : (args_u[1] & 8'h08);
                  bits_r   <= run_b;
                  bitmap_r <= 1'b1;
                  horiz_r  <= (c_sel == CMD_ROW);
                  left_r   <= 3'd7;
                end
                CMD_ALL_OFF, CMD_ALL_ON, CMD_INTENSITY, CMD_LVL_ALL: begin
                  state_r <= ST_WALK;
                  wk_r    <= WK_FILL;
                  fill_r  <= '0;
                  lvl_r   <= (c_sel == CMD_ALL_OFF) ? 8'h00 :
                             ((c_sel == CMD_ALL_ON) ? LVL_FULL : run_b);
                end
                CMD_RING_SET, CMD_RING_ALL, CMD_RING_RANGE: begin
                  state_r <= ST_WALK;
                  wk_r    <= WK_RING;
                  wn_r    <= args_u[0];
                  lvl_r   <= run_b;
                  lvl_b_r <= run_b;
                  wrap_r  <= (c_sel == CMD_RING_RANGE) && !(args_u[1] < args_u[2]) &&
                             (args_u[1] <= RING_LAST);
                  if (c_sel == CMD_RING_SET) begin
                    wp_r   <= args_u[1];
                    wend_r <= args_u[1];
                  end else if (c_sel == CMD_RING_ALL) begin
                    wp_r   <= 8'h00;
                    wend_r <= RING_LAST;
                  end else begin
                    wend_r <= args_u[2];
                    if (args_u[1] <= RING_LAST || args_u[1] < args_u[2]) begin
                      wp_r <= args_u[1];
                    end else begin
                      wp_r <= 8'h00;
                    end
                  end
                end
                CMD_RGB: begin
                  red_r   <= args_u[0];
                  green_r <= args_u[1];
                  blue_r  <= run_b;
                  state_r <= ST_IDLE;
                end
                CMD_BRIGHT: begin
                  bright_r <= run_b;
                  state_r  <= ST_IDLE;
                end
                CMD_RGB_EXT: begin
                  red_r   <= args_u[2];
                  green_r <= args_u[3];
                  blue_r  <= run_b;
                  state_r <= ST_IDLE;
                end
                default: state_r <= ST_IDLE;
              endcase
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end

        ST_WALK: begin
          unique case (wk_r)
            WK_FILL: begin
              if (fill_r == LED_AW'(LED_COUNT - 1)) begin
                state_r <= ST_IDLE;
              end else begin
                fill_r <= fill_r + 1'b1;
              end
            end
            WK_GRID: begin
              if (horiz_r) begin
                wx_r <= wx_r + 8'd1;
              end else begin
                wy_r <= wy_r + 8'd1;
              end
              lvl_r  <= lvl_b_r;
              bits_r <= bits_r >> 1;
              if (left_r == 3'd0) begin
                state_r <= ST_IDLE;
              end else begin
                left_r <= left_r - 3'd1;
              end
            end
            WK_RING: begin
              lvl_r <= lvl_b_r;
              if (wrap_r && wp_r == RING_LAST) begin
                wp_r   <= 8'h00;
                wrap_r <= 1'b0;
              end else if (!wrap_r && wp_r == wend_r) begin
                state_r <= ST_IDLE;
              end else begin
                wp_r <= wp_r + 8'd1;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end

        ST_DIV: begin
          rem_r  <= div_ge ? 5'(div_sh - {1'b0, rows_r}) : div_sh[4:0];
          quo_r  <= div_q;
          dvd_r  <= dvd_r << 1;
          dcnt_r <= dcnt_r + 3'd1;
          if (dcnt_r == 3'd5) begin
            rep_r[0] <= 8'h00;
            rep_r[1] <= 8'h01;
            rep_r[2] <= (rows_r == 5'd0) ? 8'h00 : {quo_r[4], div_q, 2'b00} >> 2;
            rep_r[3] <= 8'h00;
            rep_r[4] <= 8'h02;
            rep_r[5] <= (rows_r == 5'd0) ? 8'h00 : {quo_r[4], div_q, 2'b00} >> 2;
            rep_n_r  <= 3'd6;
            rep_i_r  <= 3'd0;
            state_r  <= ST_REP;
          end
        end

        ST_REP: begin
          if (out_free) begin
            out_kind_r  <= 1'b0;
            out_data_r  <= rep_r[rep_i_r];
            out_last_r  <= (rep_i_r == rep_n_r - 3'd1);
            if (rep_i_r == rep_n_r - 3'd1) begin
              state_r <= ST_IDLE;
            end else begin
              rep_i_r <= rep_i_r + 3'd1;
            end
          end
        end

        ST_ID_RD: state_r <= ST_ID_EM;

        ST_ID_EM: begin
          if (out_free) begin
            out_kind_r  <= 1'b0;
            out_last_r  <= (idc_r == 6'd32);
            if (idc_r == 6'd0) begin
              out_data_r <= 8'h01;
            end else begin
              out_data_r <= (7'(id_ptr) < 7'(ID_BYTES)) ? id_rdata : 8'h00;
            end
            if (idc_r == 6'd32) begin
              state_r <= ST_IDLE;
            end else begin
              idc_r   <= idc_r + 6'd1;
              state_r <= ST_ID_RD;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before decode");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input ready during clearing pass");

  a_argc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmdv_r |-> (argc_r < arg_total(pend_r, RING_MAP_ARGS)))
    else $error("argument count beyond command length");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (led_we && state_r != ST_CLEAR) |-> (state_r == ST_WALK))
    else $error("LED store written outside a walk");
`endif

endmodule
